[rtl/dynamic_priority_scheduler_defines.svh]
// Assertion macros for the scheduler RTL.
// CHK_CLK: checked on each rising edge of clk, off while rst_n is low.
// CHK_ANY: checked on each rising edge of clk, also during reset.
`ifndef DYNAMIC_PRIORITY_SCHEDULER_DEFINES_SVH
`define DYNAMIC_PRIORITY_SCHEDULER_DEFINES_SVH

`ifndef ASSERT_OFF
`define CHK_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CHK_ANY(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHK_CLK(label, prop, msg)
`define CHK_ANY(label, prop, msg)
`endif

`endif

[rtl/dps_pkg.sv]
package dps_pkg;

    localparam int NUM_PROCS_DEF = 8;

    localparam int PRI_W   = 16;
    localparam int TIME_W  = 16;
    localparam int CFG_W   = 8;
    localparam int SLOT_W  = 3;
    localparam int OUTC_W  = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_RUN_PENALTY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AGING_STEP  = 1'd1;

    localparam logic [CFG_W-1:0] RUN_PENALTY_RST = 8'd4;
    localparam logic [CFG_W-1:0] AGING_STEP_RST  = 8'd1;

    localparam logic [OUTC_W-1:0] OUTC_READY    = 2'd0;
    localparam logic [OUTC_W-1:0] OUTC_BLOCKED  = 2'd1;
    localparam logic [OUTC_W-1:0] OUTC_FINISHED = 2'd2;

    localparam logic signed [PRI_W-1:0] PRI_MAX = 16'sh7FFF;
    localparam logic signed [PRI_W-1:0] PRI_MIN = -16'sh8000;

    typedef struct packed {
        logic signed [PRI_W-1:0] pri;
        logic [TIME_W-1:0]       used;
        logic [TIME_W-1:0]       rem;
        logic [TIME_W-1:0]       cd;
        logic [TIME_W-1:0]       bl;
    } dps_entry_t;

    localparam int ENTRY_W = $bits(dps_entry_t);

    typedef struct packed {
        logic accept;
        logic do_load;
        logic scan;
        logic fin_rd;
        logic fin_wr;
        logic out_load;
    } dps_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_block;
    } dps_stat_t;

    // saturate an 18-bit signed sum to the priority range
    function automatic logic signed [PRI_W-1:0] sat_pri(logic signed [PRI_W+1:0] s);
        logic signed [PRI_W-1:0] r;
        if ((s[PRI_W+1] != s[PRI_W-1]) || (s[PRI_W] != s[PRI_W-1]))
        begin
            r = s[PRI_W+1] ? PRI_MIN : PRI_MAX;
        end
        else
        begin
            r = s[PRI_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [PRI_W-1:0] pri_add(logic signed [PRI_W-1:0] a,
                                                        logic [CFG_W-1:0] b);
        logic signed [PRI_W+1:0] s;
        s = $signed({{2{a[PRI_W-1]}}, a}) + $signed({{(PRI_W+2-CFG_W){1'b0}}, b});
        return sat_pri(s);
    endfunction

    function automatic logic signed [PRI_W-1:0] pri_sub(logic signed [PRI_W-1:0] a,
                                                        logic [CFG_W-1:0] b);
        logic signed [PRI_W+1:0] s;
        s = $signed({{2{a[PRI_W-1]}}, a}) - $signed({{(PRI_W+2-CFG_W){1'b0}}, b});
        return sat_pri(s);
    endfunction

endpackage

[rtl/dps_ram.sv]
module dps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/dps_ctrl.sv]
module dps_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                mode,
    input  dps_pkg::dps_stat_t  stat,
    output dps_pkg::dps_cmd_t   cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOAD   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_FIN_RD = 3'd4;
    localparam logic [2:0] S_FIN_WR = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = (mode == dps_pkg::MODE_TICK) ? S_SCAN : S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (!stat.out_block)
                begin
                    cmd.do_load  = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FIN_RD;
            end
            S_FIN_RD:
            begin
                cmd.fin_rd = 1'b1;
                state_next = S_FIN_WR;
            end
            S_FIN_WR:
            begin
                if (!stat.out_block)
                begin
                    cmd.fin_wr   = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/dps_dp.sv]
`include "dynamic_priority_scheduler_defines.svh"

module dps_dp #(
    parameter int NUM_PROCS = dps_pkg::NUM_PROCS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [dps_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dps_pkg::CFG_W-1:0]             cfg_data,
    input  logic [dps_pkg::SLOT_W-1:0]            slot,
    input  logic signed [dps_pkg::PRI_W-1:0]      start_priority,
    input  logic [dps_pkg::TIME_W-1:0]            total_time,
    input  logic [dps_pkg::TIME_W-1:0]            block_after,
    input  logic [dps_pkg::TIME_W-1:0]            block_length,
    input  dps_pkg::dps_cmd_t                     cmd,
    output dps_pkg::dps_stat_t                    stat,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  ran_valid,
    output logic [dps_pkg::SLOT_W-1:0]            ran_slot,
    output logic [dps_pkg::OUTC_W-1:0]            outcome,
    output logic [dps_pkg::TIME_W-1:0]            used_time,
    output logic                                  all_finished
);

    localparam int IDX_W = $clog2(NUM_PROCS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PROCS - 1);

    // configuration
    logic [dps_pkg::CFG_W-1:0] pen_reg;
    logic [dps_pkg::CFG_W-1:0] age_reg;

    // latched load item
    logic [dps_pkg::SLOT_W-1:0]       slot_reg;
    logic signed [dps_pkg::PRI_W-1:0] sp_reg;
    logic [dps_pkg::TIME_W-1:0]       tt_reg;
    logic [dps_pkg::TIME_W-1:0]       ba_reg;
    logic [dps_pkg::TIME_W-1:0]       bl_reg;

    // slot status
    logic [NUM_PROCS-1:0] ready_reg;
    logic [NUM_PROCS-1:0] ready_next;
    logic [NUM_PROCS-1:0] blocked_reg;
    logic [NUM_PROCS-1:0] blocked_next;

    // scan
    logic [IDX_W-1:0]                 idx_reg;
    logic                             upd_valid_reg;
    logic [IDX_W-1:0]                 upd_idx_reg;
    logic                             found_reg;
    logic signed [dps_pkg::PRI_W-1:0] best_reg;
    logic [IDX_W-1:0]                 best_idx_reg;

    // result
    logic                          out_valid_reg;
    logic                          ran_valid_reg;
    logic [dps_pkg::SLOT_W-1:0]    ran_slot_reg;
    logic [dps_pkg::OUTC_W-1:0]    outcome_reg;
    logic [dps_pkg::TIME_W-1:0]    used_reg;
    logic                          all_finished_reg;

    // memory
    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    logic [dps_pkg::ENTRY_W-1:0]  ram_wdata;
    logic                         ram_re;
    logic [IDX_W-1:0]             ram_raddr;
    logic [dps_pkg::ENTRY_W-1:0]  ram_rdata;

    dps_pkg::dps_entry_t rd_e;
    dps_pkg::dps_entry_t load_e;
    dps_pkg::dps_entry_t upd_e;
    dps_pkg::dps_entry_t fin_e;

    logic                       slot_ok;
    logic [IDX_W-1:0]           load_idx;
    logic                       ready_i;
    logic                       blocked_i;
    logic                       unblock;
    logic                       take;
    logic                       fin_done;
    logic                       fin_block;
    logic [dps_pkg::OUTC_W-1:0] fin_outc;

    dps_ram #(
        .WIDTH (dps_pkg::ENTRY_W),
        .DEPTH (NUM_PROCS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_e     = dps_pkg::dps_entry_t'(ram_rdata);
    assign slot_ok  = (int'(slot_reg) < NUM_PROCS);
    assign load_idx = IDX_W'(slot_reg);

    assign ram_re    = cmd.scan || (cmd.fin_rd && found_reg);
    assign ram_raddr = cmd.scan ? idx_reg : best_idx_reg;

    assign load_e.pri  = sp_reg;
    assign load_e.used = '0;
    assign load_e.rem  = tt_reg;
    assign load_e.cd   = ba_reg;
    assign load_e.bl   = bl_reg;

    // per-slot tick update: aging for ready, countdown for blocked
    always_comb
    begin
        ready_i   = ready_reg[upd_idx_reg];
        blocked_i = blocked_reg[upd_idx_reg];
        upd_e     = rd_e;
        unblock   = 1'b0;
        if (ready_i)
        begin
            upd_e.pri = dps_pkg::pri_add(rd_e.pri, age_reg);
        end
        else if (blocked_i)
        begin
            if (rd_e.bl != '0)
            begin
                upd_e.bl = rd_e.bl - 1'b1;
            end
            unblock = (upd_e.bl == '0);
        end
        take = upd_valid_reg && ready_i && (!found_reg || (rd_e.pri >= best_reg));
    end

    // chosen slot: charge one unit and the penalty
    always_comb
    begin
        fin_e     = rd_e;
        fin_done  = 1'b0;
        fin_block = 1'b0;
        fin_outc  = dps_pkg::OUTC_READY;
        if (rd_e.used != '1)
        begin
            fin_e.used = rd_e.used + 1'b1;
        end
        fin_e.pri = dps_pkg::pri_sub(rd_e.pri, pen_reg);
        if (rd_e.rem <= dps_pkg::TIME_W'(1))
        begin
            fin_e.rem = '0;
            fin_done  = 1'b1;
            fin_outc  = dps_pkg::OUTC_FINISHED;
        end
        else
        begin
            fin_e.rem = rd_e.rem - 1'b1;
            if (rd_e.cd != '0)
            begin
                fin_e.cd = rd_e.cd - 1'b1;
                if (fin_e.cd == '0)
                begin
                    fin_block = 1'b1;
                    fin_outc  = dps_pkg::OUTC_BLOCKED;
                end
            end
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = upd_idx_reg;
        ram_wdata = upd_e;
        if (cmd.do_load && slot_ok)
        begin
            ram_we    = 1'b1;
            ram_waddr = load_idx;
            ram_wdata = load_e;
        end
        else if (upd_valid_reg && (ready_i || blocked_i))
        begin
            ram_we = 1'b1;
        end
        else if (cmd.fin_wr && found_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = best_idx_reg;
            ram_wdata = fin_e;
        end
    end

    always_comb
    begin
        ready_next   = ready_reg;
        blocked_next = blocked_reg;
        if (cmd.do_load && slot_ok)
        begin
            ready_next[load_idx]   = 1'b1;
            blocked_next[load_idx] = 1'b0;
        end
        if (upd_valid_reg && blocked_i && unblock)
        begin
            ready_next[upd_idx_reg]   = 1'b1;
            blocked_next[upd_idx_reg] = 1'b0;
        end
        if (cmd.fin_wr && found_reg && (fin_done || fin_block))
        begin
            ready_next[best_idx_reg]   = 1'b0;
            blocked_next[best_idx_reg] = fin_block;
        end
    end

    assign stat.scan_last = (idx_reg == LAST_IDX);
    assign stat.out_block = out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_reg       <= dps_pkg::RUN_PENALTY_RST;
            age_reg       <= dps_pkg::AGING_STEP_RST;
            ready_reg     <= '0;
            blocked_reg   <= '0;
            idx_reg       <= '0;
            upd_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    dps_pkg::REG_RUN_PENALTY: pen_reg <= cfg_data;
                    dps_pkg::REG_AGING_STEP:  age_reg <= cfg_data;
                endcase
            end
            ready_reg     <= ready_next;
            blocked_reg   <= blocked_next;
            upd_valid_reg <= cmd.scan;
            if (cmd.accept)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (take)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            slot_reg <= slot;
            sp_reg   <= start_priority;
            tt_reg   <= total_time;
            ba_reg   <= block_after;
            bl_reg   <= block_length;
        end
        upd_idx_reg <= idx_reg;
        if (take)
        begin
            best_reg     <= rd_e.pri;
            best_idx_reg <= upd_idx_reg;
        end
        if (cmd.out_load)
        begin
            all_finished_reg <= ~|(ready_next | blocked_next);
            if (cmd.fin_wr && found_reg)
            begin
                ran_valid_reg <= 1'b1;
                ran_slot_reg  <= dps_pkg::SLOT_W'(best_idx_reg);
                outcome_reg   <= fin_outc;
                used_reg      <= fin_e.used;
            end
            else
            begin
                ran_valid_reg <= 1'b0;
                ran_slot_reg  <= '0;
                outcome_reg   <= dps_pkg::OUTC_READY;
                used_reg      <= '0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign ran_valid    = ran_valid_reg;
    assign ran_slot     = ran_slot_reg;
    assign outcome      = outcome_reg;
    assign used_time    = used_reg;
    assign all_finished = all_finished_reg;

    `CHK_ANY(a_status_excl, ((ready_reg & blocked_reg) == '0), "slot both ready and blocked")
    `CHK_CLK(a_chosen_ready, (cmd.fin_wr && found_reg) |-> ready_reg[best_idx_reg], "chosen slot not ready")
    `CHK_CLK(a_wr_excl, !(upd_valid_reg && (cmd.fin_wr || cmd.do_load)), "table write collision")
    `CHK_CLK(a_active_left, (out_valid_reg && ran_valid_reg && (outcome_reg != dps_pkg::OUTC_FINISHED)) |-> !all_finished_reg, "all finished with live slot")

endmodule

[rtl/dynamic_priority_scheduler.sv]
// Dynamic priority scheduler with aging.
// Input channel (in_valid/in_stall) takes one item: mode 0 loads a process
// slot, mode 1 runs one scheduling tick. Output channel (out_valid/out_stall)
// gives exactly one result per item. cfg_we/cfg_index/cfg_data write
// run_penalty (index 0) and aging_step (index 1); the user must write them only
// while the block is idle, as the block itself does not enforce it. The slot
// table lives in one RAM; a tick reads every slot in turn, ages or counts it
// down and writes it back while tracking the best ready slot, then reads and
// charges the chosen slot. A load result is registered in the load state after
// acceptance, a tick result in the finish-write state after a pass over the
// table RAM at one slot per cycle, a drain state and a finish-read state. One
// item is in work at a time; the next is taken the cycle after the result is
// registered.
// A stalled result is held in the output register; the block finishes the
// following item up to its result and waits there until the old one leaves.
// Reset: all slots empty (finished), run_penalty 4, aging_step 1; no
// table clearing is needed.
module dynamic_priority_scheduler #(
    parameter int NUM_PROCS = dps_pkg::NUM_PROCS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dps_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              mode,
    input  logic [dps_pkg::SLOT_W-1:0]        slot,
    input  logic signed [dps_pkg::PRI_W-1:0]  start_priority,
    input  logic [dps_pkg::TIME_W-1:0]        total_time,
    input  logic [dps_pkg::TIME_W-1:0]        block_after,
    input  logic [dps_pkg::TIME_W-1:0]        block_length,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              ran_valid,
    output logic [dps_pkg::SLOT_W-1:0]        ran_slot,
    output logic [dps_pkg::OUTC_W-1:0]        outcome,
    output logic [dps_pkg::TIME_W-1:0]        used_time,
    output logic                              all_finished
);

    dps_pkg::dps_cmd_t  cmd;
    dps_pkg::dps_stat_t stat;

    dps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .stat     (stat),
        .cmd      (cmd)
    );

    dps_dp #(
        .NUM_PROCS (NUM_PROCS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .slot           (slot),
        .start_priority (start_priority),
        .total_time     (total_time),
        .block_after    (block_after),
        .block_length   (block_length),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .ran_valid      (ran_valid),
        .ran_slot       (ran_slot),
        .outcome        (outcome),
        .used_time      (used_time),
        .all_finished   (all_finished)
    );

endmodule
